[hdl/websocket_frame_deframer_defines.svh]
// Assertion macros for the WebSocket frame deframer.
// Used by the RTL modules that carry concurrent assertions; needs clock and reset in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define WSFD_ASSERT_SAME(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define WSFD_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[hdl/wsfd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsfd_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0]            REG_MAX_PAYLOAD_LEN = 1'b0;
   localparam logic [CSR_DATA_W-1:0] LIMIT_RESET         = 32'd2048;

   // Header decoding
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   // Bytes still expected in a multi-byte header field, minus one
   localparam logic [2:0] EXT16_CNT = 3'd1;
   localparam logic [2:0] EXT64_CNT = 3'd7;
   localparam logic [2:0] KEY_CNT   = 3'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       last_of_frame;
      logic       fin_flag;
      logic [3:0] frame_opcode;
      logic       was_masked;
      logic       over_limit;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/wsfd_csr.sv]
// APB-style register file of the deframer: holds the payload length limit.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_csr
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [CSR_DATA_W-1:0] max_len
);

   logic [CSR_DATA_W-1:0] max_len_ff;
   logic [CSR_DATA_W-1:0] max_len_in;
   logic                  hit;

   assign hit    = (paddr[CSR_ADDR_W-1] == REG_MAX_PAYLOAD_LEN);
   assign pready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && hit) begin
         max_len_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LIMIT_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign prdata  = hit ? max_len_ff : '0;
   assign max_len = max_len_ff;

endmodule

`default_nettype wire

[hdl/wsfd_parser.sv]
// Frame header state machine and payload unmasking, one stream byte per step.
// Depends on wsfd_pkg and websocket_frame_deframer_defines.svh.
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic [7:0]            byte_in,
   input  wire logic [CSR_DATA_W-1:0] max_len,
   output logic                       res_valid,
   output rsp_type                    res
);

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_KEY  = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [2:0]  count_ff, count_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   logic        len_done;
   logic        hdr_done;
   logic        emit;
   logic        has_data;
   logic        last;
   logic [7:0]  data;
   logic [7:0]  key_byte;

   always_comb begin
      unique case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      length_in  = length_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      key_idx_in = key_idx_ff;
      len_done   = 1'b0;
      hdr_done   = 1'b0;
      emit       = 1'b0;
      has_data   = 1'b0;
      last       = 1'b0;
      data       = '0;

      unique case (phase_ff)
         PH_HDR1: begin
            mask_in   = byte_in[7];
            length_in = '0;
            if (byte_in[6:0] == LEN_EXT16) begin
               count_in = EXT16_CNT;
               phase_in = PH_EXT;
            end else if (byte_in[6:0] == LEN_EXT64) begin
               count_in = EXT64_CNT;
               phase_in = PH_EXT;
            end else begin
               length_in = {57'd0, byte_in[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXT: begin
            length_in = {length_ff[55:0], byte_in};
            if (count_ff == '0) begin
               len_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], byte_in};
            if (count_ff == '0) begin
               hdr_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_PAY: begin
            emit       = 1'b1;
            has_data   = 1'b1;
            last       = (remain_ff == 64'd1);
            data       = mask_ff ? (byte_in ^ key_byte) : byte_in;
            remain_in  = remain_ff - 64'd1;
            key_idx_in = key_idx_ff + 2'd1;
            if (last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // First header byte; unused codes land here too
            fin_in    = byte_in[7];
            opcode_in = byte_in[3:0];
            phase_in  = PH_HDR1;
         end
      endcase

      if (len_done) begin
         if (mask_in) begin
            key_in   = '0;
            count_in = KEY_CNT;
            phase_in = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         key_idx_in = '0;
         remain_in  = length_in;
         if (length_in == '0) begin
            emit     = 1'b1;
            last     = 1'b1;
            phase_in = PH_HDR0;
         end else begin
            phase_in = PH_PAY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         fin_ff     <= 1'b0;
         opcode_ff  <= '0;
         mask_ff    <= 1'b0;
         length_ff  <= '0;
         key_ff     <= '0;
         count_ff   <= '0;
         remain_ff  <= '0;
         key_idx_ff <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         mask_ff    <= mask_in;
         length_ff  <= length_in;
         key_ff     <= key_in;
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         key_idx_ff <= key_idx_in;
      end
   end

   assign res_valid         = step_en && emit;
   assign res.data_byte     = data;
   assign res.has_data      = has_data;
   assign res.last_of_frame = last;
   assign res.fin_flag      = fin_in;
   assign res.frame_opcode  = opcode_in;
   assign res.was_masked    = mask_in;
   assign res.over_limit    = (length_in[63:32] != '0) || (length_in[31:0] > max_len);

   `WSFD_ASSERT_SAME(a_pay_emits, step_en && (phase_ff == PH_PAY), res_valid && res.has_data, "payload byte gave no data word")
   `WSFD_ASSERT_SAME(a_hdr0_silent, step_en && (phase_ff == PH_HDR0), !res_valid, "first header byte gave a word")
   `WSFD_ASSERT_NEXT(a_last_rearms, res_valid && res.last_of_frame, phase_ff == PH_HDR0, "frame end did not return to header")
   `WSFD_ASSERT_SAME(a_marker_empty, res_valid && !res.has_data, res.last_of_frame && (res.data_byte == '0) && (res.over_limit == 1'b0), "bad empty frame marker")

endmodule

`default_nettype wire

[hdl/wsfd_outreg.sv]
// Result register of the deframer: holds one word until the receiver takes it.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_outreg
   import wsfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   output logic         slot_free,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Slot is free when empty or being drained in this cycle
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[hdl/websocket_frame_deframer.sv]
// Top level of the WebSocket frame deframer: input register, parser, result register, CSR.
// Depends on wsfd_pkg, wsfd_csr, wsfd_parser and wsfd_outreg.
//
// Usage:
//  - req channel: one raw stream byte per word (req_in_byte), frames back to back.
//  - rsp channel: one word per payload byte, unmasked, with the frame's FIN bit,
//    opcode, mask flag and over-limit flag; a zero-length frame gives a single
//    marker word with has_data low. Header bytes give no word.
//  - CSR port (APB style, pready tied high): register 0 at byte address 0 holds
//    max_payload_len, reset 2048. Write it only while the block is idle.
//  - Path: an accepted byte waits in the input register, is decoded by the parser
//    and its word is loaded into the result register, which presents it on rsp.
//  - Throughput: one byte per cycle sustained while rsp_ready stays high; set by the
//    header state machine, whose state feeds back into the next byte's decode.
//  - Stall: while rsp_ready is low and a word waits, the parser holds and the input
//    register keeps one more byte; req_ready then drops. Nothing is dropped.
//  - Reset (synchronous, active high): empties both registers, returns the parser
//    to the first header byte and reloads the limit.
`default_nettype none

module websocket_frame_deframer
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_in_byte,
   // Result stream
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [7:0]            rsp_data_byte,
   output logic                       rsp_has_data,
   output logic                       rsp_last_of_frame,
   output logic                       rsp_fin_flag,
   output logic      [3:0]            rsp_frame_opcode,
   output logic                       rsp_was_masked,
   output logic                       rsp_over_limit,
   // Configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  slot_free;
   logic                  step_en;
   logic                  res_valid;
   rsp_type               res;
   rsp_type               rsp_data;
   logic [CSR_DATA_W-1:0] max_len;

   wsfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .max_len (max_len)
   );

   // Advance the held byte whenever the result slot can take a word
   assign step_en   = in_valid_ff && slot_free;
   assign req_ready = !in_valid_ff || step_en;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the byte; payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .byte_in   (in_byte_ff),
      .max_len   (max_len),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_data_byte     = rsp_data.data_byte;
   assign rsp_has_data      = rsp_data.has_data;
   assign rsp_last_of_frame = rsp_data.last_of_frame;
   assign rsp_fin_flag      = rsp_data.fin_flag;
   assign rsp_frame_opcode  = rsp_data.frame_opcode;
   assign rsp_was_masked    = rsp_data.was_masked;
   assign rsp_over_limit    = rsp_data.over_limit;

endmodule

`default_nettype wire

[tb/sv/wsfd_deframe_checker.sv]
// Stream checker for the WebSocket frame deframer: watches both channels and the CSR port.
// Predicts each result word from the accepted bytes and compares it; depends on wsfd_pkg.
`default_nettype none

module wsfd_deframe_checker
   import wsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [7:0]            rsp_data_byte,
   input  wire logic                  rsp_has_data,
   input  wire logic                  rsp_last_of_frame,
   input  wire logic                  rsp_fin_flag,
   input  wire logic [3:0]            rsp_frame_opcode,
   input  wire logic                  rsp_was_masked,
   input  wire logic                  rsp_over_limit,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,
   output int                         fail_count,
   output int                         words_pending
);

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_MAX_PAYLOAD_LEN);

   typedef enum logic [2:0] {
      AWAIT_HDR0,
      AWAIT_HDR1,
      IN_EXT_LEN,
      IN_MASK_KEY,
      IN_PAYLOAD
   } parse_state_type;

   parse_state_type parse_state;
   logic            cur_fin;
   logic [3:0]      cur_opcode;
   logic            cur_masked;
   logic [63:0]     declared_len;
   logic [31:0]     key_word;
   logic [2:0]      bytes_left;
   logic [63:0]     payload_idx;
   logic [31:0]     limit_shadow;
   rsp_type         expected_words[$];

   function automatic rsp_type frame_word(input logic [7:0] data, input logic has,
                                          input logic last);
      rsp_type w;
      w.data_byte     = data;
      w.has_data      = has;
      w.last_of_frame = last;
      w.fin_flag      = cur_fin;
      w.frame_opcode  = cur_opcode;
      w.was_masked    = cur_masked;
      w.over_limit    = declared_len > 64'(limit_shadow);
      return w;
   endfunction

   // Append a predicted word at the tail of the queue
   function automatic void queue_word(input rsp_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   // Length and key known: an empty frame yields its marker word here
   function automatic void header_complete();
      payload_idx = '0;
      if (declared_len == 64'd0) begin
         queue_word(frame_word(8'h00, 1'b0, 1'b1));
         parse_state = AWAIT_HDR0;
      end else begin
         parse_state = IN_PAYLOAD;
      end
   endfunction

   function automatic void length_complete();
      if (cur_masked) begin
         key_word    = '0;
         bytes_left  = KEY_CNT;
         parse_state = IN_MASK_KEY;
      end else begin
         header_complete();
      end
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic       last;
      unique case (parse_state)
         AWAIT_HDR1: begin
            cur_masked   = b[7];
            declared_len = '0;
            if (b[6:0] == LEN_EXT16) begin
               bytes_left  = EXT16_CNT;
               parse_state = IN_EXT_LEN;
            end else if (b[6:0] == LEN_EXT64) begin
               bytes_left  = EXT64_CNT;
               parse_state = IN_EXT_LEN;
            end else begin
               declared_len = 64'(b[6:0]);
               length_complete();
            end
         end
         IN_EXT_LEN: begin
            declared_len = {declared_len[55:0], b};
            if (bytes_left == 3'd0) length_complete();
            else bytes_left = bytes_left - 3'd1;
         end
         IN_MASK_KEY: begin
            key_word = {key_word[23:0], b};
            if (bytes_left == 3'd0) header_complete();
            else bytes_left = bytes_left - 3'd1;
         end
         IN_PAYLOAD: begin
            // key bytes run from the top of the key word down
            key_byte = cur_masked ? key_word[31 - 8 * payload_idx[1:0] -: 8] : 8'h00;
            last     = (payload_idx == declared_len - 64'd1);
            queue_word(frame_word(b ^ key_byte, 1'b1, last));
            payload_idx = payload_idx + 64'd1;
            if (last) parse_state = AWAIT_HDR0;
         end
         default: begin
            cur_fin     = b[7];
            cur_opcode  = b[3:0];
            parse_state = AWAIT_HDR1;
         end
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
      if (seen !== want) begin
         fail_count++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         parse_state  = AWAIT_HDR0;
         cur_fin      = 1'b0;
         cur_opcode   = '0;
         cur_masked   = 1'b0;
         declared_len = '0;
         key_word     = '0;
         bytes_left   = '0;
         payload_idx  = '0;
         limit_shadow = LIMIT_RESET;
         fail_count   = 0;
         expected_words.delete();
      end else begin
         // check the outgoing word first: it cannot stem from a byte taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t unexpected word: expected none, actual data %0h last %0b",
                        $time, rsp_data_byte, rsp_last_of_frame);
            end else begin
               want = expected_words.pop_front();
               compare_field("data_byte", want.data_byte, rsp_data_byte);
               compare_field("has_data", want.has_data, rsp_has_data);
               compare_field("last_of_frame", want.last_of_frame, rsp_last_of_frame);
               compare_field("fin_flag", want.fin_flag, rsp_fin_flag);
               compare_field("frame_opcode", want.frame_opcode, rsp_frame_opcode);
               compare_field("was_masked", want.was_masked, rsp_was_masked);
               compare_field("over_limit", want.over_limit, rsp_over_limit);
            end
         end
         if (req_valid && req_ready) predict_byte(req_in_byte);
         if (psel && penable && pready && paddr == LIMIT_ADDR) begin
            if (pwrite) limit_shadow = pwdata;
            else compare_field("prdata", limit_shadow, prdata);
         end
      end
      words_pending = expected_words.size();
   end

endmodule

`default_nettype wire

[tb/sv/tb_websocket_frame_deframer.sv]
// Top of the WebSocket frame deframer testbench: clock, reset, frame stimulus, CSR writes.
// Depends on wsfd_pkg, websocket_frame_deframer and wsfd_deframe_checker.
`default_nettype none

module tb_websocket_frame_deframer;
   import wsfd_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 80;
   localparam int BYTES_PER_STEP = 250;
   localparam int NUM_STEPS      = 6;
   localparam int TIMEOUT_TICKS  = 8_000_000;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_MAX_PAYLOAD_LEN);

   typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [7:0]            rsp_data_byte;
   logic                  rsp_has_data;
   logic                  rsp_last_of_frame;
   logic                  rsp_fin_flag;
   logic [3:0]            rsp_frame_opcode;
   logic                  rsp_was_masked;
   logic                  rsp_over_limit;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int words_pending;
   int bytes_sent    = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;   // bumped by the stimulus only
   int holds_served  = 0;   // bumped by the receiver only
   int hold_left     = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   websocket_frame_deframer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_fin_flag      (rsp_fin_flag),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_was_masked    (rsp_was_masked),
      .rsp_over_limit    (rsp_over_limit),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   wsfd_deframe_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_fin_flag      (rsp_fin_flag),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_was_masked    (rsp_was_masked),
      .rsp_over_limit    (rsp_over_limit),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .words_pending     (words_pending)
   );

   // Receiver: stall at random, or hold off for a long stretch when the stimulus asks.
   // Change ready at the falling edge only, so the rising edge sees it settled.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         hold_left    = LONG_HOLD;
         holds_served = holds_served + 1;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Offer one stream byte and hold it until the block takes it.
   // Enter and leave at a falling edge; leave valid high so back-to-back words need no
   // second assignment in one step.
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   // Send one frame: header byte, length in the given form, optional key, then
   // body_bytes random payload bytes (fewer than body_len only for the endless tail frame).
   task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                             input logic [31:0] key, input logic [63:0] body_len,
                             input len_form_type form, input int body_bytes);
      push_byte(hdr0);
      case (form)
         FORM_EXT16: begin
            push_byte({masked, LEN_EXT16});
            push_byte(body_len[15:8]);
            push_byte(body_len[7:0]);
         end
         FORM_EXT64: begin
            push_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) push_byte(body_len[8 * i +: 8]);
         end
         default: begin
            push_byte({masked, body_len[6:0]});
         end
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
      for (int i = 0; i < body_bytes; i++) push_byte(8'($urandom));
   endtask

   // Drop valid, wait for every expected word, then let the input register empty out.
   task automatic settle_stream();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the payload limit, then read it back for the checker.
   task automatic write_limit(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      psel    <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [63:0]  body_len;
      len_form_type form;
      int           pick;
      int           step_goal;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int step = 0; step < NUM_STEPS; step++) begin
         // idle pattern: sender light and receiver heavy, then swapped, then none at all
         if (step < 2) begin
            req_idle_pct = 23;
            rsp_idle_pct = 78;
         end else if (step < 4) begin
            req_idle_pct = 78;
            rsp_idle_pct = 23;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         // limit per step: reset value first, then both extremes and a few in between
         case (step)
            1: write_limit(32'd0);
            2: write_limit(32'd6);
            3: write_limit(32'($urandom_range(1, 200)));
            4: write_limit(32'($urandom));
            5: write_limit(32'hFFFF_FFFF);
            default: ;
         endcase

         if (step == 0) begin
            // empty frame, plain 7-bit length: marker word straight after the length byte
            send_frame(8'h81, 1'b0, 32'h0, 64'd0, FORM_SHORT, 0);
            // empty masked frame with a 16-bit length of zero: marker after the key
            send_frame(8'h09, 1'b1, 32'hFFFF_FFFF, 64'd0, FORM_EXT16, 0);
            // reserved bits set, FIN clear, one masked byte
            send_frame(8'h72, 1'b1, 32'hFFFF_FFFF, 64'd1, FORM_SHORT, 1);
            // 64-bit length form carrying a one-byte body
            send_frame(8'hFF, 1'b0, 32'h0, 64'd1, FORM_EXT64, 1);
         end

         // with no idling, hold the receiver off so the block backs up into the sender
         if (step == 4) hold_requests = hold_requests + 1;

         step_goal = bytes_sent + BYTES_PER_STEP;
         while (bytes_sent < step_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               form     = FORM_SHORT;
               body_len = 64'($urandom_range(0, 12));
            end else if (pick < 75) begin
               form     = FORM_SHORT;
               body_len = 64'($urandom_range(13, 125));
            end else if (pick < 90) begin
               form     = FORM_EXT16;
               body_len = 64'($urandom_range(0, 160));
            end else if (pick < 98) begin
               form     = FORM_EXT64;
               body_len = 64'($urandom_range(0, 40));
            end else begin
               // exercise the upper byte of the 16-bit length
               form     = FORM_EXT16;
               body_len = 64'($urandom_range(256, 400));
            end
            send_frame(8'($urandom), 1'($urandom), 32'($urandom), body_len, form,
                       int'(body_len));
         end
         settle_stream();
      end

      // Close with a frame whose 64-bit length has its top bits set and exceeds any limit;
      // it never ends, so send only part of its body.
      send_frame(8'($urandom), 1'($urandom), 32'($urandom),
                 {32'hFFFF_FFFF, 32'($urandom)}, FORM_EXT64, 20);
      settle_stream();

      if (fail_count == 0 && words_pending == 0) begin
         $display("tb_websocket_frame_deframer: done, clean");
      end else begin
         $display("tb_websocket_frame_deframer: done, errors");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #TIMEOUT_TICKS;
      $display("tb_websocket_frame_deframer: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
